// ===== rtl/qpt_pkg.sv =====
// Shared types and constants for the quaternion pose transform.
`timescale 1ns / 1ps

package qpt_pkg;

    localparam int CoordW   = 32;
    localparam int QuatW    = 18;
    localparam int FracBits = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_QUAT_W   = 3'd3,
        REG_QUAT_X   = 3'd4,
        REG_QUAT_Y   = 3'd5,
        REG_QUAT_Z   = 3'd6
    } cfg_reg_t;

    localparam logic signed [QuatW-1:0] QuatOne = 18'sd65536;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [CoordW-1:0] moved_x;
        logic signed [CoordW-1:0] moved_y;
        logic signed [CoordW-1:0] moved_z;
    } moved_t;

endpackage

// ===== rtl/quaternion_pose_transform_top.sv =====
// Quaternion rotation plus translation of Q16.16 points, five-stage pipeline.
// One point enters per cycle and passes through the stages in order: stage 1 forms
// qv x p products, stage 2 rounds t = 2*(qv x p), stage 3 forms qv x t and w*t
// products, stage 4 sums the four terms, stage 5 rounds and saturates into the output
// register. Sustained rate is one transaction per cycle; the only limit is out_stall,
// which freezes the whole pipeline while a finished result waits (in_stall follows it
// in the same cycle). The pose (7 registers, cfg_ready always high) must only change
// while the pipeline is empty.
`timescale 1ns / 1ps

module quaternion_pose_transform_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qpt_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [qpt_pkg::CfgDataW-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  qpt_pkg::point_t                in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output qpt_pkg::moved_t                out_data
);
    import qpt_pkg::*;

    localparam int ProdW = QuatW + CoordW;       // qv * p
    localparam int CrsW  = ProdW + 1;            // qv x p
    localparam int TW    = CrsW - (FracBits - 1); // t at Q.16
    localparam int Prod2W = QuatW + TW;          // qv * t, w * t
    localparam int AccW  = Prod2W + 4;
    localparam int RndW  = AccW - FracBits;

    // pose registers
    logic signed [CoordW-1:0] off_reg [3];
    logic signed [QuatW-1:0]  qw_reg, qx_reg, qy_reg, qz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
            qw_reg     <= QuatOne;
            qx_reg     <= '0;
            qy_reg     <= '0;
            qz_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OFFSET_X: off_reg[0] <= cfg_data;
                REG_OFFSET_Y: off_reg[1] <= cfg_data;
                REG_OFFSET_Z: off_reg[2] <= cfg_data;
                REG_QUAT_W:   qw_reg <= cfg_data[QuatW-1:0];
                REG_QUAT_X:   qx_reg <= cfg_data[QuatW-1:0];
                REG_QUAT_Y:   qy_reg <= cfg_data[QuatW-1:0];
                REG_QUAT_Z:   qz_reg <= cfg_data[QuatW-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipeline moves unless a finished result is held off
    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage 1: qv x p partial products, c[i] = a[i] - b[i]
    logic signed [CoordW-1:0] px, py, pz;
    logic signed [ProdW-1:0]  s1_a_next [3];
    logic signed [ProdW-1:0]  s1_b_next [3];
    logic signed [ProdW-1:0]  s1_a_reg  [3];
    logic signed [ProdW-1:0]  s1_b_reg  [3];
    logic signed [CoordW-1:0] s1_p_reg  [3];

    assign px = in_data.point_x;
    assign py = in_data.point_y;
    assign pz = in_data.point_z;

    always_comb
    begin
        s1_a_next[0] = qy_reg * pz;
        s1_b_next[0] = qz_reg * py;
        s1_a_next[1] = qz_reg * px;
        s1_b_next[1] = qx_reg * pz;
        s1_a_next[2] = qx_reg * py;
        s1_b_next[2] = qy_reg * px;
    end

    // stage 2: t = 2*(qv x p) rounded half up to Q.16
    logic signed [CrsW-1:0] s2_c      [3];
    logic signed [TW-1:0]   s2_t_next [3];
    logic signed [TW-1:0]   s2_t_reg  [3];
    logic signed [CoordW-1:0] s2_p_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_c[i] = CrsW'(s1_a_reg[i]) - CrsW'(s1_b_reg[i]);
            s2_t_next[i] = TW'((s2_c[i] + CrsW'(1 <<< (FracBits - 2))) >>> (FracBits - 1));
        end
    end

    // stage 3: qv x t partial products and w*t
    logic signed [Prod2W-1:0] s3_a_next [3];
    logic signed [Prod2W-1:0] s3_b_next [3];
    logic signed [Prod2W-1:0] s3_w_next [3];
    logic signed [Prod2W-1:0] s3_a_reg  [3];
    logic signed [Prod2W-1:0] s3_b_reg  [3];
    logic signed [Prod2W-1:0] s3_w_reg  [3];
    logic signed [CoordW-1:0] s3_p_reg  [3];

    always_comb
    begin
        s3_a_next[0] = qy_reg * s2_t_reg[2];
        s3_b_next[0] = qz_reg * s2_t_reg[1];
        s3_a_next[1] = qz_reg * s2_t_reg[0];
        s3_b_next[1] = qx_reg * s2_t_reg[2];
        s3_a_next[2] = qx_reg * s2_t_reg[1];
        s3_b_next[2] = qy_reg * s2_t_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            s3_w_next[i] = qw_reg * s2_t_reg[i];
        end
    end

    // stage 4: exact sum at scale 2^-32
    logic signed [AccW-1:0] s4_acc_next [3];
    logic signed [AccW-1:0] s4_acc_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_acc_next[i] = (AccW'(s3_p_reg[i]) <<< FracBits)
                           + AccW'(s3_w_reg[i])
                           + AccW'(s3_a_reg[i]) - AccW'(s3_b_reg[i])
                           + (AccW'(off_reg[i]) <<< FracBits);
        end
    end

    // stage 5: round half up to Q16.16 and saturate
    localparam logic signed [RndW-1:0] SatMax = RndW'(64'sh7FFF_FFFF);
    localparam logic signed [RndW-1:0] SatMin = -RndW'(64'sh8000_0000);

    logic signed [RndW-1:0]   s5_r   [3];
    logic signed [CoordW-1:0] s5_sat [3];
    moved_t                   out_next;
    moved_t                   out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_r[i] = RndW'((s4_acc_reg[i] + AccW'(1 <<< (FracBits - 1))) >>> FracBits);
            priority if (s5_r[i] > SatMax)
                s5_sat[i] = s5_r[i] > SatMax ? CoordW'(SatMax) : '0;
            else if (s5_r[i] < SatMin)
                s5_sat[i] = CoordW'(SatMin);
            else
                s5_sat[i] = CoordW'(s5_r[i]);
        end
        out_next.moved_x = s5_sat[0];
        out_next.moved_y = s5_sat[1];
        out_next.moved_z = s5_sat[2];
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_p_reg[0] <= px;
            s1_p_reg[1] <= py;
            s1_p_reg[2] <= pz;
            for (int i = 0; i < 3; i++)
            begin
                s1_a_reg[i]   <= s1_a_next[i];
                s1_b_reg[i]   <= s1_b_next[i];
                s2_t_reg[i]   <= s2_t_next[i];
                s2_p_reg[i]   <= s1_p_reg[i];
                s3_a_reg[i]   <= s3_a_next[i];
                s3_b_reg[i]   <= s3_b_next[i];
                s3_w_reg[i]   <= s3_w_next[i];
                s3_p_reg[i]   <= s2_p_reg[i];
                s4_acc_reg[i] <= s4_acc_next[i];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted transaction did not enter stage 1");

    a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg,
                                            s4_valid_reg}))
        else $error("pipeline moved while output was stalled");

    a_output_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> out_valid == $past(s4_valid_reg))
        else $error("output valid does not follow stage 4");
`endif

endmodule

// ===== bench/quaternion_pose_transform_check.sv =====
// Pose transform checker: tracks register writes, predicts each point's result, compares outputs.
`timescale 1ns / 1ps

module quaternion_pose_transform_check
    import qpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  point_t             in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  moved_t             out_data,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int ReportLimit = 10;

    // pose as last written, held at full precision
    longint offset_fix [3];
    longint rot_w;
    longint rot_v [3];

    moved_t pending_moves [$];
    moved_t oldest_move;
    int     mismatch_total = 0;

    function automatic longint round_half_up(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic moved_t transform_point(input point_t pt);
        longint p [3];
        longint c [3];
        longint t [3];
        longint d [3];
        longint r [3];
        longint acc;
        moved_t res;
        p[0] = longint'(pt.point_x);
        p[1] = longint'(pt.point_y);
        p[2] = longint'(pt.point_z);
        // qv x p, exact at 2^-32
        c[0] = rot_v[1] * p[2] - rot_v[2] * p[1];
        c[1] = rot_v[2] * p[0] - rot_v[0] * p[2];
        c[2] = rot_v[0] * p[1] - rot_v[1] * p[0];
        // doubling folded into the shift: t lands at 2^-16
        for (int i = 0; i < 3; i++)
            t[i] = round_half_up(c[i], FracBits - 1);
        d[0] = rot_v[1] * t[2] - rot_v[2] * t[1];
        d[1] = rot_v[2] * t[0] - rot_v[0] * t[2];
        d[2] = rot_v[0] * t[1] - rot_v[1] * t[0];
        for (int i = 0; i < 3; i++) begin
            acc = (p[i] <<< FracBits) + rot_w * t[i] + d[i] + (offset_fix[i] <<< FracBits);
            acc = round_half_up(acc, FracBits);
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            else if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            r[i] = acc;
        end
        res.moved_x = r[0][CoordW-1:0];
        res.moved_y = r[1][CoordW-1:0];
        res.moved_z = r[2][CoordW-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                offset_fix[i] = 0;
                rot_v[i] = 0;
            end
            rot_w = longint'(QuatOne);
            pending_moves.delete();
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OFFSET_X: offset_fix[0] = longint'($signed(cfg_data));
                    REG_OFFSET_Y: offset_fix[1] = longint'($signed(cfg_data));
                    REG_OFFSET_Z: offset_fix[2] = longint'($signed(cfg_data));
                    REG_QUAT_W:   rot_w = longint'($signed(cfg_data[QuatW-1:0]));
                    REG_QUAT_X:   rot_v[0] = longint'($signed(cfg_data[QuatW-1:0]));
                    REG_QUAT_Y:   rot_v[1] = longint'($signed(cfg_data[QuatW-1:0]));
                    REG_QUAT_Z:   rot_v[2] = longint'($signed(cfg_data[QuatW-1:0]));
                    default: ;  // index past the register list: dropped
                endcase
            end
            if (in_valid && !in_stall)
                pending_moves.push_back(transform_point(in_data));
            if (out_valid && !out_stall)
            begin
                if (pending_moves.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= ReportLimit)
                        $display("%0t: result with none pending: (%0d, %0d, %0d)", $realtime,
                                 out_data.moved_x, out_data.moved_y, out_data.moved_z);
                end
                else
                begin
                    oldest_move = pending_moves.pop_front();
                    if (out_data.moved_x !== oldest_move.moved_x ||
                        out_data.moved_y !== oldest_move.moved_y ||
                        out_data.moved_z !== oldest_move.moved_z)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= ReportLimit)
                            $display("%0t: moved point mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                     $realtime, oldest_move.moved_x, oldest_move.moved_y,
                                     oldest_move.moved_z, out_data.moved_x, out_data.moved_y,
                                     out_data.moved_z);
                    end
                end
            end
            outstanding <= pending_moves.size();
            mismatches <= mismatch_total;
        end
    end

endmodule

// ===== bench/quaternion_pose_transform_top_test.sv =====
// Pose transform testbench top: clock, reset, pose writes, point traffic, output stalls, verdict.
`timescale 1ns / 1ps

module quaternion_pose_transform_top_test;

    import qpt_pkg::*;

    localparam int QuietLimit  = 2000;
    localparam int DrainSlack  = 8;
    localparam int PhaseCount  = 14;
    localparam int PhasePoints = 110;
    localparam int CalmPhases  = 2;

    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    point_t              in_data;
    logic                out_valid;
    logic                out_stall;
    moved_t              out_data;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int gap_odds = 0;
    bit calm = 1'b0;

    quaternion_pose_transform_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    quaternion_pose_transform_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ends the run if the channels go quiet for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            3:
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 5))
            0, 1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2:
                case ($urandom_range(0, 2))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    default: return 32'h0000_0000;
                endcase
            default: return $urandom();
        endcase
    endfunction

    // low 18 bits carry the Q2.16 value, upper bits are junk the block must drop
    function automatic logic [31:0] pick_quat();
        logic [31:0]      r;
        logic [QuatW-1:0] v;
        r = $urandom();
        v = r[QuatW-1:0];
        case ($urandom_range(0, 7))
            0, 1:
                case ($urandom_range(0, 6))
                    0: v = 18'h1_0000;
                    1: v = 18'h3_0000;
                    2: v = 18'h0_B505;
                    3: v = 18'h3_4AFB;
                    4: v = 18'h0_8000;
                    5: v = 18'h3_8000;
                    default: v = 18'h0_0000;
                endcase
            2:
                case ($urandom_range(0, 2))
                    0: v = 18'h1_FFFF;
                    1: v = 18'h2_0000;
                    default: v = 18'h0_0000;
                endcase
            3, 4: v = QuatW'($urandom_range(0, 8192) - 4096);
            default: ;
        endcase
        return {r[31:QuatW], v};
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_pose(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                             input logic [31:0] qw, input logic [31:0] qx, input logic [31:0] qy,
                             input logic [31:0] qz, input bit stray);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
        write_reg(REG_QUAT_W, qw);
        write_reg(REG_QUAT_X, qx);
        write_reg(REG_QUAT_Y, qy);
        write_reg(REG_QUAT_Z, qz);
        if (stray)
            write_reg(RegUnused, $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic send_xyz(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        point_t pt;
        pt.point_x = x;
        pt.point_y = y;
        pt.point_z = z;
        if (gap_odds != 0 && $urandom_range(1, 8) <= gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // lower valid, let the pipeline empty, then a few spare cycles
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DrainSlack) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        gap_odds = calm ? 0 : $urandom_range(0, 4);
        load_pose(pick_offset(), pick_offset(), pick_offset(), pick_quat(), pick_quat(),
                  pick_quat(), pick_quat(), $urandom_range(0, 3) == 0);
        repeat (count)
            send_xyz(pick_coord(), pick_coord(), pick_coord());
        drain();
    endtask

    // downstream back-pressure: bursts of stall between quiet stretches of varying length
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 160)) @(posedge clk);
            else
                repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity pose from reset
        gap_odds = 2;
        send_xyz(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_xyz(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_xyz(32'h0001_0000, 32'hFFFF_8000, 32'h0000_8000);
        send_xyz(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
        drain();

        // non-unit extremes, junk in the upper quaternion bits, write past the register list
        load_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hABCD_FFFF, 32'h0002_0000,
                  32'hFFFD_FFFF, 32'h5556_0000, 1'b1);
        send_xyz(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_xyz(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_xyz(32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_FFFF);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();

        // quarter turn about z with the lowest offsets
        load_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_B505, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_B505, 1'b0);
        send_xyz(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_xyz(32'h0000_8000, 32'hFFFF_7FFF, 32'h0000_0001);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();

        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            if (ph >= PhaseCount - CalmPhases)
                calm = 1'b1;
            random_phase(PhasePoints);
        end

        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
